>>> hdl/tlsf_pkg.sv
// Shared constants, types and helper functions of the TLSF class bitmap engine.
package tlsf_pkg;

  localparam int FlClasses  = 24;
  localparam int SlLog2     = 5;
  localparam int AlignLog2  = 4;
  localparam int CountWidth = 16;

  localparam int SlCount    = 1 << SlLog2;
  localparam int FlShift    = SlLog2 + AlignLog2;
  localparam int NumClasses = FlClasses * SlCount;
  localparam int IdxW       = $clog2(NumClasses);
  localparam int FlIdxW     = $clog2(FlClasses);

  localparam int ValW    = 35;
  localparam int MsbW    = 6;
  localparam int FlW     = 5;
  localparam int SlW     = 5;
  localparam int StatusW = 3;

  localparam int AlignMask = (1 << AlignLog2) - 1;
  localparam int MinUser   = 16;
  localparam int GapMin    = 32;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [ValW-1:0]       SmallSize = ValW'(1) << FlShift;
  localparam logic [CountWidth-1:0] CountMax  = '1;

  typedef enum logic [1:0] {
    FuncInsert = 2'd0,
    FuncRemove = 2'd1,
    FuncSearch = 2'd2,
    FuncNone   = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StatOk       = 3'd0,
    StatNoFit    = 3'd1,
    StatZero     = 3'd2,
    StatEmpty    = 3'd3,
    StatOverflow = 3'd4
  } status_e;

  typedef enum logic {
    StClear,
    StRun
  } back_state_e;

  typedef struct packed {
    func_e             func;
    logic              zero;
    logic              oversize;
    logic [FlW-1:0]    fl;
    logic [SlLog2-1:0] sl;
  } class_req_t;

  // Position of the leading one; zero for a zero word.
  function automatic logic [MsbW-1:0] msb_pos(input logic [ValW-1:0] v);
    logic [MsbW-1:0] n;
    n = '0;
    for (int i = 0; i < ValW; i++) begin
      if (v[i]) n = MsbW'(i);
    end
    return n;
  endfunction

  // Position of the lowest one; zero for a zero word.
  function automatic logic [4:0] lowest_set(input logic [31:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

endpackage

>>> hdl/tlsf_class_bitmap_engine.sv
// Top level of the TLSF two-level segregated fit class index engine.
// After reset the block sweeps its 768-entry class count memory to zero,
// one entry per cycle, and holds busy high while it sweeps. After
// that a request (insert, remove or search) is taken at each edge where
// start is high and busy is low. The front end rounds and maps the size
// over two register stages, a two-entry queue decouples it from the back end,
// and the back end reads the class count from memory and updates counts and
// bitmaps in the cycle after the read. Steady throughput is one request per
// cycle. The result strobe rises after the two front stages, the queue, the
// execute stage and the output register. After the sweep, busy rises only
// when the front stages back up. Each result shows on the result ports for
// exactly one cycle with valid_o high and cannot be held off by the receiver.
module tlsf_class_bitmap_engine import tlsf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [31:0]        byte_size_i,
  input  logic [4:0]         align_log2_i,
  output logic               valid_o,
  output logic [FlW-1:0]     first_level_o,
  output logic [SlW-1:0]     second_level_o,
  output logic [StatusW-1:0] status_o
);

  logic       front_ready, accept, clearing;
  logic       push, full, q_valid, pop;
  class_req_t push_data, q_data;

  // Hold off requests during the clear sweep and while the front stalls.
  assign busy   = clearing | ~front_ready;
  assign accept = start & ~busy;

  tlsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .byte_size_i (byte_size_i),
    .align_log2_i(align_log2_i),
    .ready_o     (front_ready),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  tlsf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (q_data),
    .valid_o(q_valid),
    .full_o (full)
  );

  tlsf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (q_valid),
    .req_i         (q_data),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .valid_o       (valid_o),
    .first_level_o (first_level_o),
    .second_level_o(second_level_o),
    .status_o      (status_o)
  );

endmodule

>>> hdl/tlsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlsf_ram #(
  parameter int Width = 16,
  parameter int Depth = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/tlsf_front.sv
// Front end: size rounding and class mapping of each request.
module tlsf_front import tlsf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       func_i,
  input  logic [31:0]      byte_size_i,
  input  logic [4:0]       align_log2_i,
  output logic             ready_o,
  output logic             push_o,
  output class_req_t       push_data_o,
  input  logic             full_i
);

  logic            s1_valid_q, s1_valid_d, s1_zero_q;
  func_e           s1_func_q;
  logic [ValW-1:0] s1_val_q, s1_val_d;
  logic            s2_valid_q, s2_valid_d, s2_zero_q;
  func_e           s2_func_q;
  logic [ValW-1:0] s2_val_q, s2_val_d;
  logic            s1_move, s2_move;
  logic [MsbW-1:0] f1, f2, fl_full;
  logic [ValW-1:0] rnd, shifted;

  assign s2_move = s2_valid_q & ~full_i;
  assign s1_move = s1_valid_q & (~s2_valid_q | s2_move);
  assign ready_o = ~s1_valid_q | s1_move;

  // For searches, round to the alignment grain, apply minimum and gap.
  always_comb begin
    rnd = (ValW'(byte_size_i) + ValW'(AlignMask)) & ~ValW'(AlignMask);
    if (rnd < ValW'(MinUser)) rnd = ValW'(MinUser);
    if (align_log2_i > 5'(AlignLog2)) begin
      rnd = rnd + (ValW'(1) << align_log2_i) + ValW'(GapMin);
    end
    s1_val_d = (func_e'(func_i) == FuncSearch) ? rnd : ValW'(byte_size_i);
  end

  // Round a large search size up to the next class boundary.
  always_comb begin
    f1       = msb_pos(s1_val_q);
    s2_val_d = s1_val_q;
    if (s1_func_q == FuncSearch && s1_val_q >= SmallSize) begin
      s2_val_d = s1_val_q + ((ValW'(1) << (f1 - MsbW'(SlLog2))) - ValW'(1));
    end
  end

  // Map the size to its first- and second-level class.
  always_comb begin
    f2      = msb_pos(s2_val_q);
    shifted = s2_val_q >> (f2 - MsbW'(SlLog2));
    fl_full = f2 - MsbW'(FlShift - 1);
    push_data_o.func = s2_func_q;
    push_data_o.zero = s2_zero_q;
    if (s2_val_q < SmallSize) begin
      push_data_o.fl       = '0;
      push_data_o.sl       = s2_val_q[AlignLog2 +: SlLog2];
      push_data_o.oversize = 1'b0;
    end else begin
      push_data_o.fl       = fl_full[FlW-1:0];
      push_data_o.sl       = shifted[SlLog2-1:0];
      push_data_o.oversize = fl_full >= MsbW'(FlClasses);
    end
  end

  assign push_o = s2_valid_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_i)     s1_valid_d = 1'b1;
    else if (s1_move) s1_valid_d = 1'b0;
    s2_valid_d = s2_valid_q;
    if (s1_move)      s2_valid_d = 1'b1;
    else if (s2_move) s2_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_func_q <= func_e'(func_i);
      s1_zero_q <= (byte_size_i == '0);
      s1_val_q  <= s1_val_d;
    end
    if (s1_move) begin
      s2_func_q <= s1_func_q;
      s2_zero_q <= s1_zero_q;
      s2_val_q  <= s2_val_d;
    end
  end

endmodule

>>> hdl/tlsf_queue.sv
// Short queue of mapped requests between the front and back ends.
module tlsf_queue import tlsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  class_req_t data_i,
  input  logic       pop_i,
  output class_req_t data_o,
  output logic       valid_o,
  output logic       full_o
);

  class_req_t       entries_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push, do_pop;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == (QPtrW+1)'(QDepth);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= data_i;
  end

endmodule

>>> hdl/tlsf_back.sv
// Back end: class count update, bitmap maintenance and fit search.
module tlsf_back import tlsf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  class_req_t       req_i,
  output logic             pop_o,
  output logic             clearing_o,
  output logic             valid_o,
  output logic [FlW-1:0]   first_level_o,
  output logic [SlW-1:0]   second_level_o,
  output logic [StatusW-1:0] status_o
);

  back_state_e           state_q, state_d;
  logic [IdxW-1:0]       clr_cnt_q;
  logic [FlClasses-1:0]  l1_q, l1_d;
  logic [SlCount-1:0]    l2_q [FlClasses];
  logic [SlCount-1:0]    l2_d [FlClasses];
  logic                  e_valid_q;
  class_req_t            e_req_q;
  logic                  fwd_q, fwd_d;
  logic [CountWidth-1:0] fwd_val_q;

  logic                  we, ex_we;
  logic [IdxW-1:0]       waddr, raddr, ex_addr;
  logic [CountWidth-1:0] wdata, ex_wdata, rdata, cnt;

  logic [FlW-1:0]        res_fl;
  logic [SlW-1:0]        res_sl;
  status_e               res_st;
  logic                  out_valid_q;
  logic [FlW-1:0]        out_fl_q;
  logic [SlW-1:0]        out_sl_q;
  status_e               out_st_q;
  logic [FlClasses-1:0]  row_any;

  // Sequencer: sweep the count memory after reset, then run.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_cnt_q == IdxW'(NumClasses - 1)) state_d = StRun;
      StRun:   state_d = StRun;
      default: state_d = StClear;
    endcase
  end

  always_comb begin
    pop_o      = 1'b0;
    clearing_o = 1'b0;
    unique case (state_q)
      StClear: clearing_o = 1'b1;
      StRun:   pop_o      = req_valid_i;
      default: clearing_o = 1'b1;
    endcase
  end

  assign raddr   = req_i.oversize ? '0 : IdxW'({req_i.fl, req_i.sl});
  assign ex_addr = IdxW'({e_req_q.fl, e_req_q.sl});
  assign cnt     = fwd_q ? fwd_val_q : rdata;

  // Execute the request whose count read returned this cycle.
  always_comb begin
    logic [FlIdxW-1:0]  fl_ix, fl2;
    logic [SlCount-1:0] row, row2, sl_bit, sl_map, row_new;
    logic [FlClasses-1:0] fl_map;
    logic [4:0]         low;
    fl_ix   = e_req_q.oversize ? '0 : e_req_q.fl[FlIdxW-1:0];
    row     = l2_q[fl_ix];
    sl_bit  = SlCount'(1) << e_req_q.sl;
    sl_map  = row & (~SlCount'(0) << e_req_q.sl);
    fl_map  = l1_q & (~FlClasses'(0) << ({1'b0, e_req_q.fl} + 6'd1));
    low     = lowest_set(32'(fl_map));
    fl2     = low[FlIdxW-1:0];
    row2    = l2_q[fl2];
    row_new = row & ~sl_bit;
    l1_d     = l1_q;
    l2_d     = l2_q;
    ex_we    = 1'b0;
    ex_wdata = cnt;
    res_fl   = e_req_q.fl;
    res_sl   = SlW'(e_req_q.sl);
    res_st   = StatOk;
    if (e_valid_q) begin
      unique case (e_req_q.func)
        FuncInsert: begin
          if (e_req_q.oversize) res_st = StatNoFit;
          else if (cnt == CountMax) res_st = StatOverflow;
          else begin
            ex_we        = 1'b1;
            ex_wdata     = cnt + 1'b1;
            l2_d[fl_ix]  = row | sl_bit;
            l1_d[fl_ix]  = 1'b1;
          end
        end
        FuncRemove: begin
          if (e_req_q.oversize) res_st = StatNoFit;
          else if (cnt == '0) res_st = StatEmpty;
          else begin
            ex_we    = 1'b1;
            ex_wdata = cnt - 1'b1;
            if (cnt == CountWidth'(1)) begin
              l2_d[fl_ix] = row_new;
              if (row_new == '0) l1_d[fl_ix] = 1'b0;
            end
          end
        end
        FuncSearch: begin
          if (e_req_q.zero) begin
            res_fl = '0;
            res_sl = '0;
            res_st = StatZero;
          end else if (e_req_q.oversize) begin
            res_st = StatNoFit;
          end else if (sl_map != '0) begin
            res_sl = lowest_set(32'(sl_map));
          end else if (fl_map == '0) begin
            res_st = StatNoFit;
          end else begin
            res_fl = FlW'(fl2);
            if (row2 == '0) res_st = StatNoFit;
            else res_sl = lowest_set(32'(row2));
          end
        end
        default: begin
          res_fl = '0;
          res_sl = '0;
        end
      endcase
    end
  end

  // Memory write: zero sweep while clearing, otherwise the count update.
  assign we    = (state_q == StClear) | ex_we;
  assign waddr = (state_q == StClear) ? clr_cnt_q : ex_addr;
  assign wdata = (state_q == StClear) ? '0 : ex_wdata;
  // Bypass a count that is being written as the same class is read.
  assign fwd_d = pop_o & ex_we & (ex_addr == raddr);

  tlsf_ram #(
    .Width(CountWidth),
    .Depth(NumClasses)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      l1_q        <= '0;
      e_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < FlClasses; i++) l2_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      if (state_q == StClear) clr_cnt_q <= clr_cnt_q + 1'b1;
      l1_q        <= l1_d;
      l2_q        <= l2_d;
      e_valid_q   <= pop_o;
      fwd_q       <= fwd_d;
      out_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) e_req_q <= req_i;
    fwd_val_q <= ex_wdata;
    out_fl_q  <= res_fl;
    out_sl_q  <= res_sl;
    out_st_q  <= res_st;
  end

  assign valid_o        = out_valid_q;
  assign first_level_o  = out_fl_q;
  assign second_level_o = out_sl_q;
  assign status_o       = out_st_q;

  always_comb begin
    for (int i = 0; i < FlClasses; i++) row_any[i] = |l2_q[i];
  end

  a_result_follows_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(e_valid_q))
    else $error("result without executed request");

  a_l1_matches_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    l1_q == row_any)
    else $error("first-level bitmap out of step with second-level rows");

  a_no_exec_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClear |-> !e_valid_q && !pop_o)
    else $error("request executed during memory clear");

endmodule
